FILE: rtl/core/sha256bh_pkg.sv
// Shared types, constants and round functions of the SHA-256 block hasher.
package sha256bh_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned NumVars = 8;
	localparam int unsigned NumWin  = 16;
	localparam int unsigned NumRnd  = 64;

	typedef logic [WordW-1:0] word_t;

	// Index 0 is variable a (or chain word 0), index 7 is h.
	typedef logic [0:NumVars-1][WordW-1:0] vars_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;     // shift an incoming message word into the window
		logic advance;  // shift one expanded schedule word into the window
	} sched_ctl_t;

	typedef struct packed {
		logic seed;     // load the working variables from the chaining value
		logic step;     // run one compression round
	} round_ctl_t;

	localparam vars_t INIT_HASH = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [NumRnd] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t small_sig0(input word_t x);
		small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sig1(input word_t x);
		small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t big_sig0(input word_t x);
		big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

FILE: rtl/core/sha256bh_sched.sv
// Message schedule: a sixteen-word sliding window that expands one word a cycle while advancing.
module sha256bh_sched (
	input  logic                     clk,
	input  sha256bh_pkg::sched_ctl_t ctl,
	input  sha256bh_pkg::word_t      message_word,
	output sha256bh_pkg::word_t      sched_word
);
	import sha256bh_pkg::*;

	word_t win_q [NumWin];
	word_t expand;

	// W[t+16] from W[t], W[t+1], W[t+9], W[t+14]
	assign expand = win_q[0] + small_sig0(win_q[1]) + win_q[9] + small_sig1(win_q[14]);
	assign sched_word = win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.advance) begin
			for (int i = 0; i < NumWin - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[NumWin-1] <= ctl.load ? message_word : expand;
		end
	end

endmodule

FILE: rtl/core/sha256bh_round.sv
// Compression round unit: holds a..h and applies one round per step.
module sha256bh_round (
	input  logic                     clk,
	input  sha256bh_pkg::round_ctl_t ctl,
	input  sha256bh_pkg::vars_t      seed_vars,
	input  sha256bh_pkg::word_t      sched_word,
	input  sha256bh_pkg::word_t      round_k,
	output sha256bh_pkg::vars_t      work_vars
);
	import sha256bh_pkg::*;

	vars_t work_q;
	word_t choose;
	word_t major;
	word_t sum1;
	word_t sum2;

	always_comb begin
		choose = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		major  = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		sum1   = work_q[7] + big_sig1(work_q[4]) + choose + round_k + sched_word;
		sum2   = big_sig0(work_q[0]) + major;
	end

	always_ff @(posedge clk) begin
		if (ctl.seed) begin
			work_q <= seed_vars;
		end else if (ctl.step) begin
			work_q[0] <= sum1 + sum2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + sum1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	assign work_vars = work_q;

endmodule

FILE: rtl/core/sha256bh_pkg_dummy_never.sv
// Round counter and round-constant lookup for the compression sequence.
module sha256bh_rctr (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic                step,
	output logic                last_round,
	output sha256bh_pkg::word_t round_k
);
	import sha256bh_pkg::*;

	logic [$clog2(NumRnd)-1:0] rnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (clear) begin
			rnd_q <= '0;
		end else if (step) begin
			rnd_q <= rnd_q + 1'b1;
		end
	end

	assign last_round = (rnd_q == ($clog2(NumRnd))'(NumRnd - 1));
	assign round_k    = ROUND_K[rnd_q];

endmodule

FILE: rtl/core/sha256_block_hasher_unit.sv
// Top level of the SHA-256 block hasher: word intake, sequencer, chaining value, digest out.
// Sequence: a block's sixteenth word is followed by compression (a seed step, the
// 64 rounds in the single round unit, a chaining add); a final block then offers its eight
// digest words from the next cycle, one per handshake. No new message words are taken
// until compression of a 512-bit block is through (and any digest words are taken).
// Reset (arst_n, asynchronous, low): initial hash, counters cleared; window and a..h not reset.
module sha256_block_hasher_unit (
	input  logic                clk,
	input  logic                arst_n,
	// message word channel
	input  logic                msg_valid,
	output logic                msg_ready,
	input  sha256bh_pkg::word_t message_word,
	input  logic                first_block,
	input  logic                final_block,
	// digest word channel
	output logic                digest_valid,
	input  logic                digest_ready,
	output sha256bh_pkg::word_t digest_word,
	output logic [2:0]          word_index,
	output logic                last_word
);
	import sha256bh_pkg::*;

	state_t     state_q;
	state_t     state_nxt;
	sched_ctl_t sched_ctl;
	round_ctl_t round_ctl;
	logic       rnd_clear;
	logic       last_round;
	word_t      round_k;
	word_t      sched_word;
	vars_t      seed_vars;
	vars_t      work_vars;
	vars_t      chain_q;
	logic [3:0] wcnt_q;
	logic [2:0] idx_q;
	logic       first_q;
	logic       final_q;
	logic       msg_acc;
	logic       dig_acc;
	logic       block_done;

	assign msg_acc    = msg_valid && msg_ready;
	assign dig_acc    = digest_valid && digest_ready;
	// the sixteenth word of a block closes it; only its flags count
	assign block_done = msg_acc && (wcnt_q == 4'd15);

	// a first block starts from the initial hash, otherwise chain on
	assign seed_vars = first_q ? INIT_HASH : chain_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (block_done) state_nxt = ST_INIT;
			end
			ST_INIT: begin
				state_nxt = ST_ROUND;
			end
			ST_ROUND: begin
				if (last_round) state_nxt = ST_ADD;
			end
			ST_ADD: begin
				state_nxt = final_q ? ST_EMIT : ST_LOAD;
			end
			ST_EMIT: begin
				if (dig_acc && idx_q == 3'd7) state_nxt = ST_LOAD;
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		msg_ready         = 1'b0;
		digest_valid      = 1'b0;
		sched_ctl.load    = 1'b0;
		sched_ctl.advance = 1'b0;
		round_ctl.seed    = 1'b0;
		round_ctl.step    = 1'b0;
		rnd_clear         = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				msg_ready      = 1'b1;
				sched_ctl.load = msg_acc;
			end
			ST_INIT: begin
				round_ctl.seed = 1'b1;
				rnd_clear      = 1'b1;
			end
			ST_ROUND: begin
				round_ctl.step    = 1'b1;
				sched_ctl.advance = 1'b1;
			end
			ST_ADD: begin
			end
			ST_EMIT: begin
				digest_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			wcnt_q  <= '0;
			idx_q   <= '0;
			first_q <= 1'b0;
			final_q <= 1'b0;
			chain_q <= INIT_HASH;
		end else begin
			state_q <= state_nxt;
			// advance the word count, wrapping after the sixteenth word
			if (msg_acc) begin
				wcnt_q <= wcnt_q + 1'b1;
			end
			if (block_done) begin
				first_q <= first_block;
				final_q <= final_block;
			end
			// the initial hash becomes the chaining value on a first block
			if (state_q == ST_INIT && first_q) begin
				chain_q <= INIT_HASH;
			end
			// fold the working variables back into the chaining value
			if (state_q == ST_ADD) begin
				for (int i = 0; i < NumVars; i++) begin
					chain_q[i] <= chain_q[i] + work_vars[i];
				end
			end
			// step through the digest words as each is taken
			if (dig_acc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	sha256bh_sched u_sched (
		.clk          (clk),
		.ctl          (sched_ctl),
		.message_word (message_word),
		.sched_word   (sched_word)
	);

	sha256bh_rctr u_rctr (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (rnd_clear),
		.step       (round_ctl.step),
		.last_round (last_round),
		.round_k    (round_k)
	);

	sha256bh_round u_round (
		.clk        (clk),
		.ctl        (round_ctl),
		.seed_vars  (seed_vars),
		.sched_word (sched_word),
		.round_k    (round_k),
		.work_vars  (work_vars)
	);

	// drive the digest word straight from the chaining register
	assign digest_word = chain_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

endmodule
